>>> rtl/core/ippf_pkg.sv
`timescale 1ns / 1ps
package ippf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 23;
    localparam int DIAM_W  = 17;
    localparam int SUM_W   = 18;
    localparam int SSQ_W   = 2 * SUM_W;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int R2_W    = SQ_W + 2;
    localparam int OUT_W   = 48;
    localparam int FQ_W    = OUT_W - 1;

    localparam int W2_DEN_W = R2_W + 2;
    localparam int W2_QUO_W = OUT_W;
    localparam int W2_NUM_W = W2_QUO_W + W2_DEN_W;

    localparam int T_W    = OUT_W + 4;
    localparam int T_HALF = T_W / 2;
    localparam int PROD_W = T_W + MAG_W;

    localparam int BOX_W  = 23;
    localparam int CUT_W  = 28;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [BOX_W-1:0] BOX_RESET = 23'd4689376;
    localparam logic [CUT_W-1:0] CUT_RESET = 28'd589824;

    localparam logic REG_BOX = 1'b0;
    localparam logic REG_CUT = 1'b1;

    localparam logic [OUT_W-1:0] E_CAP = {OUT_W{1'b1}};
    localparam logic signed [OUT_W-1:0] F_MIN = {1'b1, {FQ_W{1'b0}}};

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [DIAM_W-1:0]  first_diameter;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [DIAM_W-1:0]  second_diameter;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic [OUT_W-1:0]        energy_term;
        logic                    in_range;
    } out_t;

    typedef struct packed {
        logic             in_range;
        logic             zero;
        logic             pos_x;
        logic             pos_y;
        logic [MAG_W-1:0] ad_x;
        logic [MAG_W-1:0] ad_y;
        logic [R2_W-1:0]  r2;
    } side_t;

endpackage

>>> rtl/core/ippf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Quotient saturates to all ones when it does not fit QUO_W bits.
module ippf_div #(
    parameter int NUM_W  = 100,
    parameter int DEN_W  = 52,
    parameter int QUO_W  = 48,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [QUO_W:0]     valid_reg;
    logic [QUO_W:0]     ovf_reg;
    logic [DEN_W-1:0]   rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]   low_reg  [QUO_W+1];
    logic [DEN_W-1:0]   den_reg  [QUO_W+1];
    logic [QUO_W-1:0]   quo_reg  [QUO_W+1];
    logic [SIDE_W-1:0]  side_reg [QUO_W+1];

    logic [HI_W-1:0]    hi_next;
    logic               ovf_next;

    assign hi_next  = num[NUM_W-1:QUO_W];
    assign ovf_next = CMP_W'(hi_next) >= CMP_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg[0]  <= ovf_next;
        rem_reg[0]  <= DEN_W'(hi_next);
        low_reg[0]  <= num[QUO_W-1:0];
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        side_reg[0] <= in_side;
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        assign trial    = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
        assign ge       = trial >= {1'b0, den_reg[k-1]};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : trial[DEN_W-1:0];

        always_ff @(posedge clk)
        begin
            ovf_reg[k]  <= ovf_reg[k-1];
            rem_reg[k]  <= rem_next;
            low_reg[k]  <= low_reg[k-1] << 1;
            den_reg[k]  <= den_reg[k-1];
            quo_reg[k]  <= {quo_reg[k-1][QUO_W-2:0], ge};
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo       = ovf_reg[QUO_W] ? {QUO_W{1'b1}} : quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

>>> rtl/core/ippf_mul.sv
`timescale 1ns / 1ps
// 48x48 fixed-point product, floor(a*b / 2^F) clamped to 48 bits. Three stages.
module ippf_mul #(
    parameter int FRAC_BITS = ippf_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ippf_pkg::OUT_W-1:0] a,
    input  logic [ippf_pkg::OUT_W-1:0] b,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [ippf_pkg::OUT_W-1:0] prod,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int W  = ippf_pkg::OUT_W;
    localparam int H  = W / 2;
    localparam int PW = 2 * W;

    logic [2:0]        valid_reg;
    logic [W-1:0]      ll_reg, lh_reg, hl_reg, hh_reg;
    logic [PW-1:0]     sum_reg;
    logic [W-1:0]      prod_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg;

    logic [PW-1:0]     sum_next;
    logic [PW-1:0]     shift_val;
    logic [W-1:0]      prod_next;

    assign sum_next  = {hh_reg, ll_reg} + (PW'(lh_reg) << H) + (PW'(hl_reg) << H);
    assign shift_val = sum_reg >> FRAC_BITS;
    assign prod_next = (|shift_val[PW-1:W]) ? ippf_pkg::E_CAP : shift_val[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg    <= a[H-1:0] * b[H-1:0];
        lh_reg    <= a[H-1:0] * b[W-1:H];
        hl_reg    <= a[W-1:H] * b[H-1:0];
        hh_reg    <= a[W-1:H] * b[W-1:H];
        side1_reg <= in_side;
        sum_reg   <= sum_next;
        side2_reg <= side1_reg;
        prod_reg  <= prod_next;
        side3_reg <= side2_reg;
    end

    assign out_valid = valid_reg[2];
    assign prod      = prod_reg;
    assign out_side  = side3_reg;

endmodule

>>> rtl/core/inverse_power_pair_force_top.sv
`timescale 1ns / 1ps
// Inverse-power (r^-12) pair force kernel, fully pipelined.
// Throughput: one pair per cycle; busy is always low and done pulses one cycle per pair.
// Reset: rst_n asynchronous, clears the pipeline valid bits and loads the
// register defaults (box 4689376, cutoff squared 589824). The receiver cannot stall.
module inverse_power_pair_force_top #(
    parameter int FRAC_BITS = ippf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  ippf_pkg::in_t               pair,
    // result strobe
    output logic                        done,
    output ippf_pkg::out_t              result,
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ippf_pkg::ADDR_W-1:0] paddr,
    input  logic [ippf_pkg::DATA_W-1:0] pwdata,
    output logic [ippf_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int MAG_W  = ippf_pkg::MAG_W;
    localparam int R2_W   = ippf_pkg::R2_W;
    localparam int OUT_W  = ippf_pkg::OUT_W;
    localparam int DLT_W  = MAG_W + 1;           // wrapped separation
    localparam int WRP_W  = MAG_W + 3;           // room for 2*d and -L
    localparam int CUTS_W = ippf_pkg::CUT_W + FRAC_BITS;
    localparam int RC_W   = (CUTS_W > R2_W) ? CUTS_W : R2_W;
    localparam int SIDE_W = $bits(ippf_pkg::side_t);
    localparam int FN_W   = ippf_pkg::PROD_W + FRAC_BITS;

    // ---------------------------------------------------------------
    // Configuration registers; every APB transfer completes in its access cycle.
    // ---------------------------------------------------------------
    logic [ippf_pkg::BOX_W-1:0] box_reg;
    logic [ippf_pkg::CUT_W-1:0] cut_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= ippf_pkg::BOX_RESET;
            cut_reg <= ippf_pkg::CUT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ippf_pkg::REG_BOX: box_reg <= pwdata[ippf_pkg::BOX_W-1:0];
                ippf_pkg::REG_CUT: cut_reg <= pwdata[ippf_pkg::CUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ippf_pkg::REG_BOX: prdata = ippf_pkg::DATA_W'(box_reg);
            ippf_pkg::REG_CUT: prdata = ippf_pkg::DATA_W'(cut_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Minimum image: subtract L if 2d > L, then add L if 2d < -L, once each.
    // ---------------------------------------------------------------
    function automatic logic signed [DLT_W-1:0] wrap_axis(
        input logic [ippf_pkg::COORD_W-1:0] first,
        input logic [ippf_pkg::COORD_W-1:0] second,
        input logic [ippf_pkg::BOX_W-1:0]   len
    );
        logic signed [WRP_W-1:0] d;
        logic signed [WRP_W-1:0] l;
        d = $signed(WRP_W'(second)) - $signed(WRP_W'(first));
        l = $signed(WRP_W'(len));
        if ((d <<< 1) > l)
        begin
            d = d - l;
        end
        if ((d <<< 1) < -l)
        begin
            d = d + l;
        end
        return d[DLT_W-1:0];
    endfunction

    // stage 1: wrap and diameter sum
    logic                          s1_valid_reg;
    logic signed [DLT_W-1:0]       s1_dx_reg, s1_dy_reg;
    logic [ippf_pkg::SUM_W-1:0]    s1_sum_reg;
    logic                          in_xfer;

    assign in_xfer = start & ~busy;

    always_ff @(posedge clk)
    begin
        s1_dx_reg  <= wrap_axis(pair.first_x, pair.second_x, box_reg);
        s1_dy_reg  <= wrap_axis(pair.first_y, pair.second_y, box_reg);
        s1_sum_reg <= ippf_pkg::SUM_W'(pair.first_diameter) +
                      ippf_pkg::SUM_W'(pair.second_diameter);
    end

    // stage 2: magnitudes and squares
    logic                          s2_valid_reg;
    logic [MAG_W-1:0]              s2_adx_reg, s2_ady_reg;
    logic                          s2_posx_reg, s2_posy_reg;
    logic [ippf_pkg::SQ_W-1:0]     s2_x2_reg, s2_y2_reg;
    logic [ippf_pkg::SSQ_W-1:0]    s2_ssq_reg;
    logic [MAG_W-1:0]              adx_next, ady_next;

    assign adx_next = s1_dx_reg[DLT_W-1] ? MAG_W'(-s1_dx_reg) : MAG_W'(s1_dx_reg);
    assign ady_next = s1_dy_reg[DLT_W-1] ? MAG_W'(-s1_dy_reg) : MAG_W'(s1_dy_reg);

    always_ff @(posedge clk)
    begin
        s2_adx_reg  <= adx_next;
        s2_ady_reg  <= ady_next;
        s2_posx_reg <= (s1_dx_reg > 0);
        s2_posy_reg <= (s1_dy_reg > 0);
        s2_x2_reg   <= adx_next * adx_next;
        s2_y2_reg   <= ady_next * ady_next;
        s2_ssq_reg  <= s1_sum_reg * s1_sum_reg;
    end

    // stage 3: squared distance, cutoff test
    logic                          s3_valid_reg;
    ippf_pkg::side_t               s3_side_reg;
    logic [ippf_pkg::SSQ_W-1:0]    s3_ssq_reg;
    logic [R2_W-1:0]               r2_next;

    assign r2_next = R2_W'(s2_x2_reg) + R2_W'(s2_y2_reg);

    always_ff @(posedge clk)
    begin
        s3_side_reg.in_range <= RC_W'(r2_next) < (RC_W'(cut_reg) << FRAC_BITS);
        s3_side_reg.zero     <= (r2_next == '0);
        s3_side_reg.pos_x    <= s2_posx_reg;
        s3_side_reg.pos_y    <= s2_posy_reg;
        s3_side_reg.ad_x     <= s2_adx_reg;
        s3_side_reg.ad_y     <= s2_ady_reg;
        s3_side_reg.r2       <= r2_next;
        s3_ssq_reg           <= s2_ssq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // w2 = s^2 * 2^F / (4*r2), then w4, w8, w12 through the multipliers.
    // ---------------------------------------------------------------
    logic                  w2_valid;
    logic [OUT_W-1:0]      w2;
    logic [SIDE_W-1:0]     w2_side;

    ippf_div #(
        .NUM_W  (ippf_pkg::W2_NUM_W),
        .DEN_W  (ippf_pkg::W2_DEN_W),
        .QUO_W  (ippf_pkg::W2_QUO_W),
        .SIDE_W (SIDE_W)
    ) u_w2_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .num       (ippf_pkg::W2_NUM_W'(s3_ssq_reg) << FRAC_BITS),
        .den       ({s3_side_reg.r2, 2'b00}),
        .in_side   (s3_side_reg),
        .out_valid (w2_valid),
        .quo       (w2),
        .out_side  (w2_side)
    );

    logic                  w4_valid;
    logic [OUT_W-1:0]      w4;
    logic [SIDE_W-1:0]     w4_side;

    ippf_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_mul_w4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w2_valid),
        .a         (w2),
        .b         (w2),
        .in_side   (w2_side),
        .out_valid (w4_valid),
        .prod      (w4),
        .out_side  (w4_side)
    );

    logic                      w8_valid;
    logic [OUT_W-1:0]          w8;
    logic [SIDE_W+OUT_W-1:0]   w8_side;
    logic [SIDE_W-1:0]         w8_base;
    logic [OUT_W-1:0]          w8_w4;

    ippf_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W + OUT_W)) u_mul_w8 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w4_valid),
        .a         (w4),
        .b         (w4),
        .in_side   ({w4_side, w4}),
        .out_valid (w8_valid),
        .prod      (w8),
        .out_side  (w8_side)
    );

    assign {w8_base, w8_w4} = w8_side;

    logic                  w12_valid;
    logic [OUT_W-1:0]      w12;
    logic [SIDE_W-1:0]     w12_side;

    ippf_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_mul_w12 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w8_valid),
        .a         (w8),
        .b         (w8_w4),
        .in_side   (w8_base),
        .out_valid (w12_valid),
        .prod      (w12),
        .out_side  (w12_side)
    );

    // ---------------------------------------------------------------
    // Force numerator 12*w12*|d|, split as two 26x24 partials per axis.
    // ---------------------------------------------------------------
    localparam int TW = ippf_pkg::T_W;
    localparam int TH = ippf_pkg::T_HALF;
    localparam int PW = ippf_pkg::PROD_W;

    logic                  f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [TW-1:0]         f1_t_reg;
    logic [OUT_W-1:0]      f1_w12_reg, f2_w12_reg, f3_w12_reg;
    ippf_pkg::side_t       f1_side_reg, f2_side_reg, f3_side_reg;
    logic [TH+MAG_W-1:0]   f2_xlo_reg, f2_xhi_reg, f2_ylo_reg, f2_yhi_reg;
    logic [PW-1:0]         f3_px_reg, f3_py_reg;

    always_ff @(posedge clk)
    begin
        f1_t_reg    <= (TW'(w12) << 3) + (TW'(w12) << 2);
        f1_w12_reg  <= w12;
        f1_side_reg <= w12_side;

        f2_xlo_reg  <= f1_t_reg[TH-1:0]  * f1_side_reg.ad_x;
        f2_xhi_reg  <= f1_t_reg[TW-1:TH] * f1_side_reg.ad_x;
        f2_ylo_reg  <= f1_t_reg[TH-1:0]  * f1_side_reg.ad_y;
        f2_yhi_reg  <= f1_t_reg[TW-1:TH] * f1_side_reg.ad_y;
        f2_w12_reg  <= f1_w12_reg;
        f2_side_reg <= f1_side_reg;

        f3_px_reg   <= PW'(f2_xlo_reg) + (PW'(f2_xhi_reg) << TH);
        f3_py_reg   <= PW'(f2_ylo_reg) + (PW'(f2_yhi_reg) << TH);
        f3_w12_reg  <= f2_w12_reg;
        f3_side_reg <= f2_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= w12_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // |f| = floor(num * 2^F / r2), saturating at 2^47-1; x lane carries the
    // sideband, y lane carries its own sign
    logic                           fx_valid, fy_valid;
    logic [ippf_pkg::FQ_W-1:0]      fx_mag, fy_mag;
    logic [SIDE_W+OUT_W-1:0]        fx_side;
    logic [SIDE_W-1:0]              fx_base;
    ippf_pkg::side_t                fx_info;
    logic [OUT_W-1:0]               fx_w12;
    logic                           fy_pos;

    ippf_div #(
        .NUM_W  (FN_W),
        .DEN_W  (R2_W),
        .QUO_W  (ippf_pkg::FQ_W),
        .SIDE_W (SIDE_W + OUT_W)
    ) u_fx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_valid_reg),
        .num       (FN_W'(f3_px_reg) << FRAC_BITS),
        .den       (f3_side_reg.r2),
        .in_side   ({f3_side_reg, f3_w12_reg}),
        .out_valid (fx_valid),
        .quo       (fx_mag),
        .out_side  (fx_side)
    );

    ippf_div #(
        .NUM_W  (FN_W),
        .DEN_W  (R2_W),
        .QUO_W  (ippf_pkg::FQ_W),
        .SIDE_W (1)
    ) u_fy_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_valid_reg),
        .num       (FN_W'(f3_py_reg) << FRAC_BITS),
        .den       (f3_side_reg.r2),
        .in_side   (f3_side_reg.pos_y),
        .out_valid (fy_valid),
        .quo       (fy_mag),
        .out_side  (fy_pos)
    );

    assign {fx_base, fx_w12} = fx_side;
    assign fx_info = fx_base;

    // ---------------------------------------------------------------
    // Output register: sign, cutoff and zero-distance cases.
    // ---------------------------------------------------------------
    logic              done_reg;
    ippf_pkg::out_t    result_reg;
    ippf_pkg::out_t    result_next;
    logic [OUT_W-1:0]  magx_ext, magy_ext;

    assign magx_ext = OUT_W'(fx_mag);
    assign magy_ext = OUT_W'(fy_mag);

    always_comb
    begin
        result_next = '0;
        if (fx_info.in_range)
        begin
            result_next.in_range = 1'b1;
            if (fx_info.zero)
            begin
                result_next.energy_term = ippf_pkg::E_CAP;
            end
            else
            begin
                result_next.energy_term = fx_w12;
                result_next.force_x = fx_info.pos_x ? -magx_ext : magx_ext;
                result_next.force_y = fy_pos ? -magy_ext : magy_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fx_valid == fy_valid)
        else $error("force lanes out of step");

    a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.in_range |->
            result.energy_term == '0 && result.force_x == '0 && result.force_y == '0)
        else $error("nonzero result outside cutoff");

    a_no_energy_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.energy_term == '0 |-> result.force_x == '0 && result.force_y == '0)
        else $error("force without energy");

    a_force_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.force_x != ippf_pkg::F_MIN && result.force_y != ippf_pkg::F_MIN)
        else $error("force outside saturation range");

endmodule

>>> verif/tb_inverse_power_pair_force_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the r^-12 pair force kernel.
// The scoreboard predicts every pair transfer and compares each done strobe
// against the oldest expected result.
module tb_inverse_power_pair_force_top;

    localparam int LAT       = 113;     // fixed pipeline depth of the top level
    localparam int LIMIT     = 400000;  // timeout in clock cycles
    localparam int PER_PHASE = 455;     // random pairs per register setting (a quarter of it for the zero setting)

    // byte addresses of the two registers
    localparam logic [ippf_pkg::ADDR_W-1:0] ADDR_BOX =
        ippf_pkg::ADDR_W'(4 * ippf_pkg::REG_BOX);
    localparam logic [ippf_pkg::ADDR_W-1:0] ADDR_CUT =
        ippf_pkg::ADDR_W'(4 * ippf_pkg::REG_CUT);

    localparam longint unsigned F_CAP = 64'h7FFF_FFFF_FFFF;

    // Holds the register copies, predicts each pair and keeps the queue of
    // forces and energies that are still to come out of the pipeline.
    class force_scoreboard;
        logic [ippf_pkg::BOX_W-1:0] box;
        logic [ippf_pkg::CUT_W-1:0] cut;
        ippf_pkg::out_t             due_q[$];
        int                         errors;
        int                         checked;
        int                         hits;

        function new();
            box     = ippf_pkg::BOX_RESET;
            cut     = ippf_pkg::CUT_RESET;
            errors  = 0;
            checked = 0;
            hits    = 0;
        endfunction

        // minimum image, both tests applied once in this order
        function longint wrap_sep(logic [ippf_pkg::COORD_W-1:0] a,
                                  logic [ippf_pkg::COORD_W-1:0] b);
            longint d;
            longint len;
            len = longint'({41'd0, box});
            d   = longint'({41'd0, b}) - longint'({41'd0, a});
            if (2 * d > len)
                d = d - len;
            if (2 * d < -len)
                d = d + len;
            return d;
        endfunction

        // floor(a*b / 2^F), clamped to the energy cap
        function longint unsigned q_mul(longint unsigned a, longint unsigned b);
            logic [127:0] pr;
            pr = (128'(a) * 128'(b)) >> ippf_pkg::FRAC_BITS_DEF;
            if (pr > 128'(ippf_pkg::E_CAP))
                return longint'(ippf_pkg::E_CAP);
            return pr[63:0];
        endfunction

        // |f| = floor(12*w12*|d| * 2^F / r2), sign opposite to d
        function logic [ippf_pkg::OUT_W-1:0] axis_force(longint unsigned w12, longint d,
                                                        longint unsigned r2);
            logic [127:0]                 num;
            logic [127:0]                 quo;
            logic [ippf_pkg::OUT_W-1:0]   mag;
            longint unsigned              ad;
            ad  = (d < 0) ? longint'(-d) : longint'(d);
            num = (128'(12 * w12) * 128'(ad)) << ippf_pkg::FRAC_BITS_DEF;
            quo = num / 128'(r2);
            mag = (quo > 128'(F_CAP)) ? ippf_pkg::OUT_W'(F_CAP) : quo[ippf_pkg::OUT_W-1:0];
            return (d > 0) ? -mag : mag;
        endfunction

        function ippf_pkg::out_t pair_force(ippf_pkg::in_t p);
            ippf_pkg::out_t  r;
            longint          dx;
            longint          dy;
            longint unsigned adx;
            longint unsigned ady;
            longint unsigned r2;
            longint unsigned s;
            longint unsigned w2;
            longint unsigned w4;
            longint unsigned w8;
            longint unsigned w12;
            r   = '0;
            dx  = wrap_sep(p.first_x, p.second_x);
            dy  = wrap_sep(p.first_y, p.second_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            r2  = adx * adx + ady * ady;
            if (r2 >= (longint'({36'd0, cut}) << ippf_pkg::FRAC_BITS_DEF))
                return r;
            r.in_range = 1'b1;
            if (r2 == 0)
            begin
                r.energy_term = ippf_pkg::E_CAP;
                return r;
            end
            s  = longint'(p.first_diameter) + longint'(p.second_diameter);
            w2 = ((s * s) << ippf_pkg::FRAC_BITS_DEF) / (4 * r2);
            if (w2 > longint'(ippf_pkg::E_CAP))
                w2 = longint'(ippf_pkg::E_CAP);
            w4  = q_mul(w2, w2);
            w8  = q_mul(w4, w4);
            w12 = q_mul(w8, w4);
            r.force_x     = axis_force(w12, dx, r2);
            r.force_y     = axis_force(w12, dy, r2);
            r.energy_term = w12[ippf_pkg::OUT_W-1:0];
            return r;
        endfunction

        function void note_pair(ippf_pkg::in_t p);
            due_q.push_back(pair_force(p));
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string what, logic [ippf_pkg::OUT_W-1:0] got,
                    logic [ippf_pkg::OUT_W-1:0] want);
            $display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
            errors++;
        endtask

        task check_result(ippf_pkg::out_t got);
            ippf_pkg::out_t want;
            if (due_q.size() == 0)
            begin
                report("unexpected done strobe", '0, '0);
                return;
            end
            want = due_q.pop_front();
            if (got.force_x !== want.force_x)
                report("force_x", got.force_x, want.force_x);
            if (got.force_y !== want.force_y)
                report("force_y", got.force_y, want.force_y);
            if (got.energy_term !== want.energy_term)
                report("energy_term", got.energy_term, want.energy_term);
            if (got.in_range !== want.in_range)
                report("in_range", ippf_pkg::OUT_W'(got.in_range),
                       ippf_pkg::OUT_W'(want.in_range));
            if (want.in_range)
                hits++;
            checked++;
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    ippf_pkg::in_t                  pair;
    logic                           done;
    ippf_pkg::out_t                 result;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ippf_pkg::ADDR_W-1:0]    paddr;
    logic [ippf_pkg::DATA_W-1:0]    pwdata;
    logic [ippf_pkg::DATA_W-1:0]    prdata;
    logic                           pready;

    force_scoreboard sb;
    int              n_taken;   // pair transfers seen at the clock edge
    int              cycles;

    inverse_power_pair_force_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pair    (pair),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Everything is sampled here, at the rising edge, before the DUT's
    // nonblocking updates land. Inputs only move on the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_pair(pair);
                n_taken++;
            end
            if (done === 1'b1)
                sb.check_result(result);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle. pready is tied high,
    // so the register takes the value at the end of the access cycle.
    task apb_write(logic [ippf_pkg::ADDR_W-1:0] addr, logic [ippf_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers move only with the pipeline drained.
    task set_geometry(logic [ippf_pkg::BOX_W-1:0] box, logic [ippf_pkg::CUT_W-1:0] cut);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
        apb_write(ADDR_BOX, ippf_pkg::DATA_W'(box));
        apb_write(ADDR_CUT, ippf_pkg::DATA_W'(cut));
        sb.box = box;
        sb.cut = cut;
    endtask

    // Present one pair and hold it until the transfer is seen.
    // start stays high across back-to-back pairs of a burst.
    task send_pair(ippf_pkg::in_t p);
        int target;
        target = n_taken + 1;
        @(negedge clk);
        start <= 1'b1;
        pair  <= p;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (n_taken < target);
    endtask

    task idle_gap(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Mostly pairs close together so that they land inside the cutoff,
    // with a random spread of separations; the rest is full-range noise.
    function ippf_pkg::in_t random_pair();
        ippf_pkg::in_t p;
        logic [127:0]  raw;
        int            span;
        int            box_top;
        raw = {$urandom, $urandom, $urandom, $urandom};
        p   = ippf_pkg::in_t'(raw[$bits(ippf_pkg::in_t)-1:0]);
        if ($urandom_range(0, 4) == 0)
            return p;
        box_top = (sb.box > 1) ? int'(sb.box) - 1 : (1 << ippf_pkg::COORD_W) - 1;
        case ($urandom_range(0, 3))
            0:       span = 1 << 8;
            1:       span = 1 << 12;
            2:       span = 1 << 15;
            default: span = 1 << 17;
        endcase
        p.first_x  = ippf_pkg::COORD_W'($urandom_range(0, box_top));
        p.first_y  = ippf_pkg::COORD_W'($urandom_range(0, box_top));
        p.second_x = p.first_x + ippf_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
        p.second_y = p.first_y + ippf_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
        if ($urandom_range(0, 3) != 0)
        begin
            p.first_diameter  = ippf_pkg::DIAM_W'($urandom_range(32768, 98304));
            p.second_diameter = ippf_pkg::DIAM_W'($urandom_range(32768, 98304));
        end
        return p;
    endfunction

    function ippf_pkg::in_t make_pair(int ax, int ay, int bx, int by, int da, int db);
        ippf_pkg::in_t p;
        p.first_x         = ippf_pkg::COORD_W'(ax);
        p.first_y         = ippf_pkg::COORD_W'(ay);
        p.first_diameter  = ippf_pkg::DIAM_W'(da);
        p.second_x        = ippf_pkg::COORD_W'(bx);
        p.second_y        = ippf_pkg::COORD_W'(by);
        p.second_diameter = ippf_pkg::DIAM_W'(db);
        return p;
    endfunction

    task random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_pair(random_pair());
            left -= burst;
            // some bursts run straight into the next one
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 8));
        end
        idle_gap(0);
    endtask

    localparam int CMAX = (1 << ippf_pkg::COORD_W) - 1;
    localparam int DMAX = (1 << ippf_pkg::DIAM_W) - 1;
    localparam int ONE  = 1 << ippf_pkg::FRAC_BITS_DEF;

    initial
    begin
        sb      = new();
        n_taken = 0;
        cycles  = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        pair    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pairs under the reset geometry (box 71.55, cutoff 3.0)
        send_pair(make_pair(100, 200, 100, 200, ONE, ONE));          // zero distance
        send_pair(make_pair(0, 0, ONE, 0, DMAX, DMAX));              // widest diameters
        send_pair(make_pair(0, 0, ONE, ONE, 0, 0));                  // zero diameters
        send_pair(make_pair(0, 0, ONE, 0, 0, DMAX));
        send_pair(make_pair(CMAX, CMAX, CMAX - ONE, CMAX, ONE, ONE)); // beyond box
        send_pair(make_pair(0, 0, CMAX, CMAX, ONE, ONE));            // far beyond box
        send_pair(make_pair(0, 0, 3 * ONE, 0, ONE, ONE));            // exactly at cutoff
        send_pair(make_pair(0, 0, 3 * ONE - 1, 0, ONE, ONE));        // just inside
        send_pair(make_pair(0, 0, 4689375, 0, ONE, ONE));            // wraps to -1 lsb
        send_pair(make_pair(4689375, 0, 0, 5, ONE, ONE));            // wraps to +1 lsb
        send_pair(make_pair(0, 0, 2344688, 0, ONE, ONE));            // 2d equals box
        send_pair(make_pair(0, 0, 1, 0, ONE, ONE));                  // tiny gap, saturates
        send_pair(make_pair(10 * ONE, 10 * ONE, 9 * ONE, 11 * ONE, ONE, ONE));
        send_pair(make_pair(0, 0, 0, 0, 0, 0));                      // all zero
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, DMAX, DMAX));    // all ones
        idle_gap(2);
        random_phase(PER_PHASE);

        // largest box and cutoff
        set_geometry({ippf_pkg::BOX_W{1'b1}}, {ippf_pkg::CUT_W{1'b1}});
        send_pair(make_pair(0, 0, CMAX, CMAX, DMAX, DMAX));
        random_phase(PER_PHASE);

        // zero box, zero cutoff: no pair can be in range
        set_geometry('0, '0);
        send_pair(make_pair(5, 5, 5, 5, ONE, ONE));
        random_phase(PER_PHASE / 4);

        // random middle settings
        set_geometry(ippf_pkg::BOX_W'($urandom_range(ONE, CMAX)),
                     ippf_pkg::CUT_W'($urandom_range(ONE, 64 * ONE)));
        random_phase(PER_PHASE);
        set_geometry(ippf_pkg::BOX_W'($urandom_range(1, 8 * ONE)),
                     ippf_pkg::CUT_W'($urandom_range(1, 1 << (ippf_pkg::CUT_W - 1))));
        random_phase(PER_PHASE);

        // drain, then let the pipeline run out
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);

        $display("%0d pairs sent over five box/cutoff settings, %0d results checked",
                 n_taken, sb.checked);
        $display("%0d inside cutoff, %0d mismatches", sb.hits, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> inverse_power_pair_force_top.f
rtl/core/ippf_pkg.sv
rtl/core/ippf_div.sv
rtl/core/ippf_mul.sv
rtl/core/inverse_power_pair_force_top.sv
verif/tb_inverse_power_pair_force_top.sv
